>>> hw/rtl/assert_macros.svh
// assertion helpers, included by the result buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ccm_pkg.sv
`default_nettype none
package ccm_pkg;

  // color style codes
  localparam logic [1:0] STYLE_BANDS = 2'd0;
  localparam logic [1:0] STYLE_RAMP  = 2'd1;

  // normalized value h, q1.16 with one at 65536
  localparam int H_W = 17;
  localparam logic [H_W-1:0] H_HALF = 17'd32768;
  localparam logic [H_W-1:0] H_ONE  = 17'd65536;

  // shading divider widths
  localparam int X_W   = 36;
  localparam int DIV_W = 28;
  localparam int Q_W   = 8;

  // rounded bytes of 0.85 and 0.9
  localparam logic [7:0] BYTE_850 = 8'd217;
  localparam logic [7:0] BYTE_900 = 8'd230;

  // gray ramp: (510 * (0.9 * 65536000 - 700 h) + 65536000) / 131072000
  localparam logic [25:0]      GRAY_BASE = 26'd58982400;
  localparam logic [X_W-1:0]   GRAY_OFS  = 36'd65536000;
  localparam logic [DIV_W-1:0] GRAY_DIV  = 28'd131072000;

  typedef struct packed {
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [1:0]         color_style;
    logic [4:0][16:0]   scale;
  } cfg_t;

  // colors decided before the divider
  typedef struct packed {
    logic       bypass;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fixed_rgb_t;

  // stop colors in thousandths, channel 0 red, 1 green, 2 blue
  function automatic logic [9:0] stop_thou(input logic [2:0] idx, input logic [1:0] ch);
    logic [9:0] r, g, b;
    begin
      r = 10'd0;
      g = 10'd0;
      b = 10'd0;
      case (idx)
        3'd0: b = 10'd850;
        3'd1: begin g = 10'd900; b = 10'd900; end
        3'd2: g = 10'd750;
        3'd3: begin r = 10'd900; g = 10'd900; end
        3'd4: r = 10'd850;
        default: r = 10'd0;
      endcase
      case (ch)
        2'd0: return r;
        2'd1: return g;
        default: return b;
      endcase
    end
  endfunction

  // open band around k/10, bounds scaled by 1000 * 65536
  function automatic logic [26:0] band_lo(input int k);
    return 27'((100 * k - 10) * 65536);
  endfunction

  function automatic logic [26:0] band_hi(input int k);
    return 27'((100 * k + 1) * 65536);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/curvature_color_map.sv
`default_nettype none
// channel       | dir | handshake          | payload
// s_axis        | in  | tvalid / tready    | tdata[31:0] curvature, signed q16.16
// m_axis        | out | tvalid / tready    | tdata[23:0] red, green, blue
// apb config    | in  | psel/penable/pready| paddr[4:2] register, pwdata / prdata
//
// one item per cycle sustained while the result buffer is not full; an item then moves on to m_axis
// through the 17-stage normalizing divider and the 8-stage color divider
// rst is synchronous and clears all valid bits; configuration registers return to their reset values
// s_axis_tready falls only when the two-entry result buffer is full
module curvature_color_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] curvature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ccm_pkg::*;

  localparam logic [2:0] REG_LOW    = 3'd0;
  localparam logic [2:0] REG_HIGH   = 3'd1;
  localparam logic [2:0] REG_STYLE  = 3'd2;
  localparam logic [2:0] REG_SCALE0 = 3'd3;
  localparam logic [2:0] REG_SCALE1 = 3'd4;
  localparam logic [2:0] REG_SCALE2 = 3'd5;
  localparam logic [2:0] REG_SCALE3 = 3'd6;
  localparam logic [2:0] REG_SCALE4 = 3'd7;

  cfg_t                   cfg;
  logic                   wr_en;
  logic                   adv;
  logic                   full;
  logic                   norm_valid, shade_valid, div_valid;
  logic [H_W-1:0]         h;
  fixed_rgb_t             fix;
  logic [2:0][X_W-1:0]    x;
  logic [DIV_W-1:0]       divisor;
  logic [23:0]            rgb;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_bound   <= 32'sd0;
      cfg.high_bound  <= 32'sd65536;
      cfg.color_style <= STYLE_RAMP;
      cfg.scale[0]    <= 17'd0;
      cfg.scale[1]    <= 17'd16384;
      cfg.scale[2]    <= 17'd32768;
      cfg.scale[3]    <= 17'd49152;
      cfg.scale[4]    <= 17'd65536;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_LOW:    cfg.low_bound   <= pwdata;
        REG_HIGH:   cfg.high_bound  <= pwdata;
        REG_STYLE:  cfg.color_style <= pwdata[1:0];
        REG_SCALE0: cfg.scale[0]    <= pwdata[16:0];
        REG_SCALE1: cfg.scale[1]    <= pwdata[16:0];
        REG_SCALE2: cfg.scale[2]    <= pwdata[16:0];
        REG_SCALE3: cfg.scale[3]    <= pwdata[16:0];
        REG_SCALE4: cfg.scale[4]    <= pwdata[16:0];
        default:    cfg.low_bound   <= cfg.low_bound;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      REG_LOW:    prdata = cfg.low_bound;
      REG_HIGH:   prdata = cfg.high_bound;
      REG_STYLE:  prdata = {30'd0, cfg.color_style};
      REG_SCALE0: prdata = {15'd0, cfg.scale[0]};
      REG_SCALE1: prdata = {15'd0, cfg.scale[1]};
      REG_SCALE2: prdata = {15'd0, cfg.scale[2]};
      REG_SCALE3: prdata = {15'd0, cfg.scale[3]};
      REG_SCALE4: prdata = {15'd0, cfg.scale[4]};
      default:    prdata = 32'd0;
    endcase
  end

  // whole pipeline moves unless the result buffer is full
  assign adv           = !full;
  assign s_axis_tready = adv;

  ccm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .curvature (s_axis_tdata),
    .cfg       (cfg),
    .out_valid (norm_valid),
    .h         (h)
  );

  ccm_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (norm_valid),
    .h         (h),
    .cfg       (cfg),
    .out_valid (shade_valid),
    .fix       (fix),
    .x         (x),
    .divisor   (divisor)
  );

  ccm_div8 u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (shade_valid),
    .fix       (fix),
    .x         (x),
    .divisor   (divisor),
    .out_valid (div_valid),
    .rgb       (rgb)
  );

  ccm_obuf u_obuf (
    .clk           (clk),
    .rst           (rst),
    .push          (div_valid && adv),
    .din           (rgb),
    .full          (full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> hw/rtl/ccm_norm.sv
`default_nettype none
module ccm_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic signed [31:0]          curvature,
  input  ccm_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic [ccm_pkg::H_W-1:0]     h
);
  import ccm_pkg::*;

  logic [31:0]      den;
  logic [31:0]      num;
  logic [48:0]      dividend;
  logic             eq, gt, lt;
  logic             frc_in;
  logic [H_W-1:0]   hf_in;

  logic             v   [0:H_W];
  logic             frc [0:H_W];
  logic [H_W-1:0]   hf  [0:H_W];
  logic [31:0]      rem [0:H_W];
  logic [H_W-1:0]   lo  [0:H_W];
  logic [H_W-1:0]   q   [0:H_W];

  // bounds compare and rounded dividend
  assign den      = 32'(cfg.high_bound - cfg.low_bound);
  assign num      = 32'(curvature - cfg.low_bound);
  assign dividend = {1'b0, num, 16'd0} + 49'(den[31:1]);
  assign eq       = (cfg.high_bound == cfg.low_bound);
  assign gt       = ($signed(curvature) > $signed(cfg.high_bound));
  assign lt       = ($signed(curvature) < $signed(cfg.low_bound));

  always_comb begin
    frc_in = 1'b1;
    hf_in  = '0;
    if (eq) begin
      hf_in = H_HALF;
    end else if (gt) begin
      hf_in = H_ONE;
    end else if (!lt) begin
      frc_in = 1'b0;
    end
  end

  // capture stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frc[0] <= frc_in;
      hf[0]  <= hf_in;
      rem[0] <= dividend[48:17];
      lo[0]  <= dividend[16:0];
      q[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < H_W; k++) begin : g_step
    logic [32:0] rsh;
    logic        take;
    logic [31:0] rnx;

    assign rsh  = {rem[k], lo[k][H_W-1]};
    assign take = (rsh >= {1'b0, den});
    assign rnx  = take ? 32'(rsh - {1'b0, den}) : rsh[31:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        frc[k+1] <= frc[k];
        hf[k+1]  <= hf[k];
        rem[k+1] <= rnx;
        lo[k+1]  <= {lo[k][H_W-2:0], 1'b0};
        q[k+1]   <= {q[k][H_W-2:0], take};
      end
    end
  end

  assign out_valid = v[H_W];
  assign h         = frc[H_W] ? hf[H_W] : q[H_W];

endmodule
`default_nettype wire

>>> hw/rtl/ccm_shade.sv
`default_nettype none
module ccm_shade (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [ccm_pkg::H_W-1:0]         h,
  input  ccm_pkg::cfg_t                   cfg,
  output logic                            out_valid,
  output ccm_pkg::fixed_rgb_t             fix,
  output logic [2:0][ccm_pkg::X_W-1:0]    x,
  output logic [ccm_pkg::DIV_W-1:0]       divisor
);
  import ccm_pkg::*;

  logic [26:0]     hm;
  logic            band;
  logic [1:0]      seg;
  logic [16:0]     s_lo, s_hi;
  fixed_rgb_t      fix_n;
  logic            ramp_n;

  logic            va, vb;
  fixed_rgb_t      fix_a, fix_b;
  logic            ramp_a, ramp_b;
  logic [1:0]      seg_a;
  logic [16:0]     n_a, d_a, d_b;
  logic [25:0]     gb_a;
  logic [X_W-1:0]  xg_b;
  logic [2:0][26:0] mix_b;

  // band test on h * 1000
  assign hm = 27'(h) * 27'd1000;

  always_comb begin
    band = 1'b0;
    for (int k = 1; k <= 9; k++) begin
      if (hm > band_lo(k) && hm < band_hi(k)) begin
        band = 1'b1;
      end
    end
  end

  // ramp segment: first upper stop at or above h
  always_comb begin
    if (cfg.scale[1] >= h) begin
      seg = 2'd0;
    end else if (cfg.scale[2] >= h) begin
      seg = 2'd1;
    end else if (cfg.scale[3] >= h) begin
      seg = 2'd2;
    end else begin
      seg = 2'd3;
    end
  end

  assign s_lo = cfg.scale[seg];
  assign s_hi = cfg.scale[3'(seg) + 3'd1];

  // colors that need no division
  always_comb begin
    fix_n  = '0;
    ramp_n = 1'b0;
    case (cfg.color_style)
      STYLE_BANDS: begin
        fix_n.bypass = 1'b1;
        fix_n.red    = band ? 8'd0 : BYTE_900;
        fix_n.green  = band ? 8'd0 : BYTE_900;
        fix_n.blue   = band ? 8'd0 : BYTE_900;
      end
      STYLE_RAMP: begin
        if (h >= cfg.scale[4]) begin
          fix_n.bypass = 1'b1;
          fix_n.red    = BYTE_850;
        end else if (h <= cfg.scale[0]) begin
          fix_n.bypass = 1'b1;
          fix_n.blue   = BYTE_850;
        end else begin
          ramp_n = 1'b1;
        end
      end
      default: ramp_n = 1'b0;
    endcase
  end

  // stage a: decisions, segment offsets, gray base
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fix_a  <= fix_n;
      ramp_a <= ramp_n;
      seg_a  <= seg;
      n_a    <= 17'(h - s_lo);
      d_a    <= 17'(s_hi - s_lo);
      gb_a   <= 26'(GRAY_BASE - 26'(27'(h) * 27'd700));
    end
  end

  // stage b: weighted mix of the two stops per channel
  always_ff @(posedge clk) begin
    if (adv) begin
      fix_b  <= fix_a;
      ramp_b <= ramp_a;
      d_b    <= d_a;
      xg_b   <= X_W'(gb_a) * X_W'(510) + GRAY_OFS;
      for (int j = 0; j < 3; j++) begin
        mix_b[j] <= 27'(stop_thou(3'(seg_a), 2'(j))) * 27'(17'(d_a - n_a))
                  + 27'(stop_thou(3'(seg_a) + 3'd1, 2'(j))) * 27'(n_a);
      end
    end
  end

  // stage c: rounded dividend and divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      fix <= fix_b;
      for (int j = 0; j < 3; j++) begin
        x[j] <= ramp_b ? X_W'(mix_b[j]) * X_W'(510) + X_W'(d_b) * X_W'(1000) : xg_b;
      end
      divisor <= ramp_b ? DIV_W'(d_b) * DIV_W'(2000) : GRAY_DIV;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ccm_div8.sv
`default_nettype none
module ccm_div8 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  ccm_pkg::fixed_rgb_t             fix,
  input  logic [2:0][ccm_pkg::X_W-1:0]    x,
  input  logic [ccm_pkg::DIV_W-1:0]       divisor,
  output logic                            out_valid,
  output logic [23:0]                     rgb
);
  import ccm_pkg::*;

  logic                       v   [0:Q_W];
  fixed_rgb_t                 fx  [0:Q_W];
  logic [DIV_W-1:0]           dv  [0:Q_W];
  logic [2:0][DIV_W-1:0]      rem [0:Q_W];
  logic [2:0][Q_W-1:0]        lo  [0:Q_W];
  logic [2:0][Q_W-1:0]        q   [0:Q_W];

  // capture stage, quotient is known to stay below 256
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx[0] <= fix;
      dv[0] <= divisor;
      for (int j = 0; j < 3; j++) begin
        rem[0][j] <= x[j][X_W-1:Q_W];
        lo[0][j]  <= x[j][Q_W-1:0];
        q[0][j]   <= '0;
      end
    end
  end

  // one quotient bit per stage, three channels side by side
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [2:0][DIV_W:0]   rsh;
    logic [2:0]            take;
    logic [2:0][DIV_W-1:0] rnx;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rsh[j]  = {rem[k][j], lo[k][j][Q_W-1]};
        take[j] = (rsh[j] >= {1'b0, dv[k]});
        rnx[j]  = take[j] ? DIV_W'(rsh[j] - {1'b0, dv[k]}) : rsh[j][DIV_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fx[k+1] <= fx[k];
        dv[k+1] <= dv[k];
        for (int j = 0; j < 3; j++) begin
          rem[k+1][j] <= rnx[j];
          lo[k+1][j]  <= {lo[k][j][Q_W-2:0], 1'b0};
          q[k+1][j]   <= {q[k][j][Q_W-2:0], take[j]};
        end
      end
    end
  end

  assign out_valid = v[Q_W];
  assign rgb = fx[Q_W].bypass ? {fx[Q_W].blue, fx[Q_W].green, fx[Q_W].red}
                              : {q[Q_W][2], q[Q_W][1], q[Q_W][0]};

endmodule
`default_nettype wire

>>> hw/rtl/ccm_obuf.sv
`default_nettype none
module ccm_obuf (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [23:0] din,
  output logic        full,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);
  `include "assert_macros.svh"

  logic [23:0] mem [0:1];
  logic        wr, rd;
  logic [1:0]  cnt;
  logic        pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign full          = (cnt == 2'd2);
  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = mem[rd];

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= 1'b0;
      rd  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wr <= !wr;
      end
      if (pop) begin
        rd <= !rd;
      end
      cnt <= 2'(cnt + 2'(push) - 2'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= din;
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, cnt != 2'd3, "result buffer count out of range")
  `ASSERT_ALWAYS(a_no_overrun, !(push && full && !pop), "item pushed into full buffer")
  `ASSERT_NEXT(a_fill, push && !pop, cnt == 2'($past(cnt) + 2'd1), "buffer count missed push")
  `ASSERT_NEXT(a_drain, pop && !push, cnt == 2'($past(cnt) - 2'd1), "buffer count missed pop")

endmodule
`default_nettype wire
